@@ hdl/tcm_pkg.sv @@
package tcm_pkg;
  localparam int unsigned NumStatesDef  = 16;
  localparam int unsigned NumActionsDef = 4;
  localparam int unsigned CountBitsDef  = 32;
  localparam int unsigned OneCount      = 256;
  localparam int unsigned ProbBits      = 17;
  localparam int unsigned QuoBits       = 16;

  // request kinds carried on s_tuser
  localparam logic ReqLoad    = 1'b0;
  localparam logic ReqObserve = 1'b1;

  typedef enum logic [3:0] {
    StIdle,
    StChk,
    StRd,
    StUpd,
    StWalkRd,
    StWalkWait,
    StDiv,
    StEmit,
    StClear
  } tcm_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic upd_load;
    logic upd_obs;
    logic div_start;
    logic walk_first;
    logic walk_next;
    logic clr_step;
    logic out_load;
  } tcm_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_range;
    logic is_obs;
    logic div_busy;
    logic walk_last;
    logic clr_done;
    logic out_busy;
  } tcm_sts_t;
endpackage

@@ hdl/tcm_ram.sv @@
module tcm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ hdl/tcm_div.sv @@
// restoring divider, one quotient bit a cycle: floor(num * 2^16 / den), saturated
module tcm_div import tcm_pkg::*; #(
  parameter int unsigned NumW = 32,
  parameter int unsigned DenW = 38
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [NumW-1:0]     num_i,
  input  logic [DenW-1:0]     den_i,
  output logic                busy_o,
  output logic [ProbBits-1:0] quo_o
);
  localparam int unsigned RemW = DenW + 1;
  localparam int unsigned CntW = $clog2(ProbBits + 1);

  logic [RemW-1:0]      rem_q, rem_d;
  logic [DenW-1:0]      den_q;
  logic [ProbBits-1:0]  quo_q, quo_d;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q;
  logic [RemW-1:0]      trial;
  logic [ProbBits-1:0]  sat_quo;

  // integer part is 0 or 1 since num <= den after a valid update
  always_comb begin
    trial = {rem_q[RemW-2:0], 1'b0};
    rem_d = trial;
    quo_d = {quo_q[ProbBits-2:0], 1'b0};
    if (trial >= {1'b0, den_q}) begin
      rem_d = trial - {1'b0, den_q};
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= (den_i != '0);
      cnt_q  <= CntW'(QuoBits);
    end else if (busy_q) begin
      if (cnt_q == '0) busy_q <= 1'b0;
      else             cnt_q  <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      den_q <= den_i;
      // first step: integer bit
      if (den_i == '0) begin
        rem_q <= '0;
        quo_q <= '0;
      end else if (RemW'(num_i) >= RemW'(den_i)) begin
        rem_q <= RemW'(num_i) - RemW'(den_i);
        quo_q <= ProbBits'(1);
      end else begin
        rem_q <= RemW'(num_i);
        quo_q <= '0;
      end
    end else if (busy_q && cnt_q != '0) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign sat_quo = (quo_q > ProbBits'(65536)) ? ProbBits'(65536) : quo_q;
  assign quo_o   = sat_quo;
  assign busy_o  = busy_q && (cnt_q != '0);
endmodule

@@ hdl/tcm_ctrl.sv @@
module tcm_ctrl import tcm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  tcm_sts_t sts_i,
  output tcm_cmd_t cmd_o
);
  tcm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= StClear;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear:    if (sts_i.clr_done) state_d = StIdle;
      StIdle:     if (in_valid_i) state_d = StChk;
      StChk:      state_d = sts_i.in_range ? StRd : StIdle;
      StRd:       state_d = StUpd;
      StUpd:      state_d = sts_i.is_obs ? StWalkRd : StIdle;
      StWalkRd:   state_d = StWalkWait;
      StWalkWait: state_d = StDiv;
      StDiv:      if (!sts_i.div_busy) state_d = StEmit;
      StEmit: begin
        if (!sts_i.out_busy) state_d = sts_i.walk_last ? StIdle : StWalkRd;
      end
      default:    state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      StClear:    cmd_o.clr_step = 1'b1;
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StUpd: begin
        cmd_o.upd_load   = !sts_i.is_obs;
        cmd_o.upd_obs    = sts_i.is_obs;
        cmd_o.walk_first = 1'b1;
      end
      StWalkWait: cmd_o.div_start = 1'b1;
      StEmit: begin
        if (!sts_i.out_busy) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.walk_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> !in_ready_o) else $error("input taken twice");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StClear) |=> (state_q != StClear)) else $error("clear pass restarted");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv && sts_i.div_busy) |=> (state_q == StDiv))
    else $error("left division early");
endmodule

@@ hdl/tcm_dp.sv @@
module tcm_dp import tcm_pkg::*; #(
  parameter int unsigned NumStates  = NumStatesDef,
  parameter int unsigned NumActions = NumActionsDef,
  parameter int unsigned CountBits  = CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  tcm_cmd_t    cmd_i,
  output tcm_sts_t    sts_o,
  input  logic        s_tuser_i,
  input  logic [47:0] s_tdata_i,
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [23:0] m_tdata_o,
  output logic        m_tlast_o
);
  localparam int unsigned SW      = (NumStates > 1) ? $clog2(NumStates) : 1;
  localparam int unsigned NumRows = NumStates * NumActions;
  localparam int unsigned NumEnt  = NumRows * NumStates;
  localparam int unsigned RW      = $clog2(NumRows);
  localparam int unsigned EW      = $clog2(NumEnt);
  localparam int unsigned TotW    = CountBits + SW;
  localparam int unsigned CW      = CountBits + 1; // count plus reachable bit

  logic [3:0]           from_q, to_q;
  logic [1:0]           act_q;
  logic                 obs_q;
  logic [31:0]          prior_q;
  logic [SW-1:0]        y_q;
  logic [EW-1:0]        clr_q;
  logic                 walk_sel_q;
  logic [RW-1:0]        row;
  logic [EW-1:0]        base, rd_addr, wr_addr;
  logic                 c_we, t_we;
  logic [CW-1:0]        c_wdata, c_rdata;
  logic [TotW-1:0]      t_wdata, t_rdata, tot_q;
  logic [CountBits-1:0] cnt, nv;
  logic                 sat_q, sat_n;
  logic                 in_range;
  logic [ProbBits-1:0]  quo;
  logic                 div_busy;
  logic                 ov_q;
  logic [3:0]           ns_q;
  logic [ProbBits-1:0]  prob_q;
  logic                 reach_wk_q, reach_q, satout_q, last_q;

  assign in_range = (32'(from_q) < NumStates) && (32'(to_q) < NumStates)
                 && (32'(act_q) < NumActions);
  assign row     = RW'(32'(from_q) * NumActions + 32'(act_q));
  assign cnt     = c_rdata[CountBits-1:0];
  assign nv      = CountBits'(prior_q);
  assign sat_n   = cnt > CountBits'((64'(1) << CountBits) - 64'(1) - 64'(OneCount));

  // entry address: row base plus to_state, or walk index
  assign base    = EW'(32'(row) * NumStates);
  assign rd_addr = walk_sel_q ? base + EW'(y_q) : base + EW'(to_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      obs_q   <= (s_tuser_i == ReqObserve);
      from_q  <= s_tdata_i[3:0];
      act_q   <= s_tdata_i[5:4];
      to_q    <= s_tdata_i[9:6];
      prior_q <= s_tdata_i[41:10];
    end
    if (cmd_i.upd_obs) sat_q <= sat_n;
    if (cmd_i.upd_load || cmd_i.upd_obs) tot_q <= t_wdata;
  end

  always_comb begin
    c_we    = 1'b0;
    t_we    = 1'b0;
    wr_addr = base + EW'(to_q);
    c_wdata = c_rdata;
    t_wdata = t_rdata;
    if (cmd_i.clr_step) begin
      c_we = 1'b1; t_we = 1'b1; wr_addr = clr_q; c_wdata = '0; t_wdata = '0;
    end else if (cmd_i.upd_load) begin
      c_we = 1'b1; t_we = 1'b1;
      t_wdata = t_rdata - TotW'(cnt) + TotW'(nv);
      c_wdata = {c_rdata[CountBits], nv};
    end else if (cmd_i.upd_obs && !sat_n) begin
      c_we = 1'b1; t_we = 1'b1;
      t_wdata = t_rdata + TotW'(OneCount);
      c_wdata = {c_rdata[CountBits], cnt + CountBits'(OneCount)};
    end else if (cmd_i.div_start) begin
      // sticky reachable mark during walk
      wr_addr = base + EW'(y_q);
      c_we    = (cnt != '0);
      c_wdata = {1'b1, cnt};
    end
  end

  tcm_ram #(.Width(CW), .Depth(NumEnt)) u_cnt (
    .clk_i, .we_i(c_we), .waddr_i(wr_addr), .wdata_i(c_wdata),
    .raddr_i(rd_addr), .rdata_o(c_rdata)
  );

  tcm_ram #(.Width(TotW), .Depth(NumRows)) u_tot (
    .clk_i, .we_i(t_we), .waddr_i(cmd_i.clr_step ? clr_q[RW-1:0] : row),
    .wdata_i(t_wdata), .raddr_i(row), .rdata_o(t_rdata)
  );

  tcm_div #(.NumW(CountBits), .DenW(TotW)) u_div (
    .clk_i, .rst_ni, .start_i(cmd_i.div_start), .num_i(cnt), .den_i(tot_q),
    .busy_o(div_busy), .quo_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= '0;
      walk_sel_q <= 1'b0;
      y_q        <= '0;
      ov_q       <= 1'b0;
    end else begin
      if (cmd_i.clr_step) clr_q <= clr_q + EW'(1);
      if (cmd_i.walk_first) walk_sel_q <= 1'b1;
      else if (cmd_i.capture) walk_sel_q <= 1'b0;
      if (cmd_i.walk_first) y_q <= '0;
      else if (cmd_i.walk_next) y_q <= y_q + SW'(1);
      if (cmd_i.out_load) ov_q <= 1'b1;
      else if (m_tready_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) reach_wk_q <= c_rdata[CountBits] | (cnt != '0);
    if (cmd_i.out_load) begin
      ns_q     <= 4'(y_q);
      prob_q   <= quo;
      reach_q  <= reach_wk_q;
      satout_q <= sat_q;
      last_q   <= (y_q == SW'(NumStates - 1));
    end
  end

  assign sts_o.in_range  = in_range;
  assign sts_o.is_obs    = obs_q;
  assign sts_o.div_busy  = div_busy;
  assign sts_o.walk_last = (y_q == SW'(NumStates - 1));
  assign sts_o.clr_done  = (clr_q == EW'(NumEnt - 1));
  assign sts_o.out_busy  = ov_q && !m_tready_i;
  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {1'b0, satout_q, reach_q, prob_q, ns_q};
  assign m_tlast_o  = last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && !m_tready_i) |=> (ov_q && $stable(m_tdata_o) && $stable(m_tlast_o)))
    else $error("output word changed while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(ov_q && !m_tready_i)) else $error("held word overwritten");
endmodule

@@ hdl/transition_count_model.sv @@
// load word: accepted, range-checked, read and stored; no output; then s_tready again
// observe word: NUM_STATES output words, one per next state, each after a memory read,
// a restoring division and an output load; an output word waits while m_tready is low
// next input word taken only after the last output word of an observe is loaded
// after reset a clearing pass zeroes every entry of the count and total memories first
module transition_count_model import tcm_pkg::*; #(
  parameter int unsigned NUM_STATES  = NumStatesDef,
  parameter int unsigned NUM_ACTIONS = NumActionsDef,
  parameter int unsigned COUNT_BITS  = CountBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type
  input  logic        s_tuser,
  // from_state, action, to_state, prior_count
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // next_state, probability, reachable, saturated
  output logic [23:0] m_tdata,
  output logic        m_tlast
);
  tcm_cmd_t cmd;
  tcm_sts_t sts;

  tcm_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(s_tvalid), .in_ready_o(s_tready),
    .sts_i(sts), .cmd_o(cmd)
  );

  tcm_dp #(.NumStates(NUM_STATES), .NumActions(NUM_ACTIONS), .CountBits(COUNT_BITS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .s_tuser_i(s_tuser), .s_tdata_i(s_tdata),
    .m_tvalid_o(m_tvalid), .m_tready_i(m_tready), .m_tdata_o(m_tdata),
    .m_tlast_o(m_tlast)
  );
endmodule

@@ bench/tcm_checker.sv @@
`timescale 1ns / 1ps

module tcm_checker import tcm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic        s_tuser,
  input  logic [47:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [23:0] m_tdata,
  input  logic        m_tlast,
  output int          fail_cnt_o,
  output int          pending_o,
  output int          words_seen_o,
  output int          sat_seen_o
);
  localparam int unsigned NS = NumStatesDef;
  localparam int unsigned NA = NumActionsDef;

  typedef struct packed {
    logic [3:0]  next_state;
    logic [16:0] probability;
    logic        reachable;
    logic        saturated;
    logic        last;
  } row_entry_t;

  logic [31:0] counts[NS*NA*NS];
  logic [35:0] totals[NS*NA];
  logic        seen[NS*NA*NS];
  row_entry_t  expected_q[$];

  function automatic logic [16:0] ratio_q16(logic [31:0] c, logic [35:0] t);
    logic [63:0] q;
    if (t == '0) return '0;
    q = {16'd0, c, 16'd0} / {28'd0, t};
    if (q > 64'd65536) q = 64'd65536;
    return q[16:0];
  endfunction

  task automatic predict_row(logic kind, logic [47:0] d);
    logic [3:0]  from, to;
    logic [1:0]  act;
    int unsigned row, idx;
    logic        sat;
    row_entry_t  e;
    from = d[3:0];
    act = d[5:4];
    to = d[9:6];
    if (32'(from) >= NS || 32'(to) >= NS || 32'(act) >= NA) return;
    row = 32'(from) * NA + 32'(act);
    idx = row * NS + 32'(to);
    if (kind == ReqLoad) begin
      totals[row] = totals[row] - 36'(counts[idx]) + 36'(d[41:10]);
      counts[idx] = d[41:10];
      return;
    end
    sat = 1'b0;
    if (counts[idx] > 32'hFFFF_FFFF - 32'(OneCount)) begin
      sat = 1'b1;
    end else begin
      counts[idx] += 32'(OneCount);
      totals[row] += 36'(OneCount);
    end
    for (int y = 0; y < NS; y++) begin
      if (counts[row*NS+y] != 0) seen[row*NS+y] = 1'b1;
      e.next_state = y[3:0];
      e.probability = ratio_q16(counts[row*NS+y], totals[row]);
      e.reachable = seen[row*NS+y];
      e.saturated = sat;
      e.last = (y == NS - 1);
      expected_q.push_back(e);
    end
  endtask

  always @(posedge clk_i) begin
    row_entry_t exp_e;
    int         errs;
    errs = 0;
    if (!rst_ni) begin
      for (int i = 0; i < NS*NA*NS; i++) begin
        counts[i] = '0;
        seen[i] = 1'b0;
      end
      for (int i = 0; i < NS*NA; i++) totals[i] = '0;
      expected_q.delete();
    end else begin
      if (s_tvalid && s_tready) predict_row(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        words_seen_o <= words_seen_o + 1;
        if (m_tdata[22]) sat_seen_o <= sat_seen_o + 1;
        if (expected_q.size() == 0) begin
          $error("unexpected word %h", m_tdata);
          errs++;
        end else begin
          exp_e = expected_q.pop_front();
          if (m_tdata[3:0] != exp_e.next_state) begin
            $error("next_state exp %0d got %0d", exp_e.next_state, m_tdata[3:0]);
            errs++;
          end
          if (m_tdata[20:4] != exp_e.probability) begin
            $error("probability exp %0d got %0d", exp_e.probability, m_tdata[20:4]);
            errs++;
          end
          if (m_tdata[21] != exp_e.reachable) begin
            $error("reachable exp %0d got %0d", exp_e.reachable, m_tdata[21]);
            errs++;
          end
          if (m_tdata[22] != exp_e.saturated) begin
            $error("saturated exp %0d got %0d", exp_e.saturated, m_tdata[22]);
            errs++;
          end
          if (m_tlast != exp_e.last) begin
            $error("last exp %0d got %0d", exp_e.last, m_tlast);
            errs++;
          end
        end
      end
    end
    fail_cnt_o <= fail_cnt_o + errs;
    pending_o <= expected_q.size();
  end
endmodule

@@ bench/tb_transition_count_model.sv @@
`timescale 1ns / 1ps

module tb_transition_count_model import tcm_pkg::*; ();
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic        s_tuser = 1'b0;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic        m_tlast;
  int          fail_cnt, pending, words_seen, sat_seen;
  int          send_idle = 0, recv_stall = 0;
  int          loads_sent = 0, observes_sent = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  transition_count_model i_dut (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast
  );

  tcm_checker i_checker (
    .clk_i, .rst_ni, .s_tvalid, .s_tready, .s_tuser, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tlast,
    .fail_cnt_o(fail_cnt), .pending_o(pending),
    .words_seen_o(words_seen), .sat_seen_o(sat_seen)
  );

  // receiver back-pressure, redrawn every falling edge
  always @(negedge clk_i) m_tready <= ($urandom_range(99) >= recv_stall);

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(logic kind, logic [3:0] from, logic [1:0] act,
                           logic [3:0] to, logic [31:0] cnt);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_tuser <= kind;
    s_tdata <= {6'd0, cnt, to, act, from};
    s_tvalid <= 1'b1;
    while (!s_tready) @(negedge clk_i);
    @(posedge clk_i);
    if (kind == ReqLoad) loads_sent++;
    else observes_sent++;
    @(negedge clk_i);
  endtask

  task automatic random_word();
    int r;
    logic [3:0] f, t;
    logic [1:0] a;
    r = $urandom_range(99);
    // most traffic lands on a few hot rows so counts build up
    f = 4'($urandom_range(3));
    a = 2'($urandom_range(3));
    t = 4'($urandom_range(15));
    if (r < 10) f = 4'($urandom_range(15));
    if (r < 25)
      send_word(ReqLoad, f, a, t, (r < 5) ? $urandom : $urandom_range(4096));
    else if (r < 30)
      send_word(ReqLoad, f, a, t, 32'hFFFF_FF00 - 256 * $urandom_range(2));
    else
      send_word(ReqObserve, f, a, t, $urandom);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, saturation, load of zero keeps reachable
    send_word(ReqObserve, 4'd0, 2'd0, 4'd0, 32'h0);
    send_word(ReqObserve, 4'd15, 2'd3, 4'd15, 32'hFFFF_FFFF);
    send_word(ReqLoad, 4'd15, 2'd3, 4'd0, 32'hFFFF_FFFF);
    send_word(ReqObserve, 4'd15, 2'd3, 4'd0, 32'h0);
    send_word(ReqLoad, 4'd15, 2'd3, 4'd0, 32'hFFFF_FE00);
    send_word(ReqObserve, 4'd15, 2'd3, 4'd0, 32'h0);
    send_word(ReqObserve, 4'd15, 2'd3, 4'd0, 32'h0);
    send_word(ReqLoad, 4'd0, 2'd0, 4'd0, 32'h0);
    send_word(ReqObserve, 4'd0, 2'd0, 4'd5, 32'h0);
    send_word(ReqLoad, 4'd7, 2'd1, 4'd9, 32'h0000_0001);
    send_word(ReqLoad, 4'd7, 2'd1, 4'd10, 32'h5555_5555);
    send_word(ReqObserve, 4'd7, 2'd1, 4'd9, 32'hAAAA_AAAA);
    send_word(ReqLoad, 4'd10, 2'd2, 4'd5, 32'hAAAA_AAAA);
    send_word(ReqObserve, 4'd10, 2'd2, 4'd5, 32'h5555_5555);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 65 : 12) : 0;
      recv_stall = (ph == 2) ? 65 : ((ph == 3) ? 12 : 0);
      repeat (100) random_word();
    end
    s_tvalid <= 1'b0;
    send_idle = 0;
    recv_stall = 0;
    while (pending != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("sent %0d loads, %0d observes; checked %0d words, %0d saturated",
             loads_sent, observes_sent, words_seen, sat_seen);
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("timeout");
    $display("== FAIL ==");
    $finish;
  end
endmodule

@@ transition_count_model.f @@
hdl/tcm_pkg.sv
hdl/tcm_ram.sv
hdl/tcm_div.sv
hdl/tcm_ctrl.sv
hdl/tcm_dp.sv
hdl/transition_count_model.sv
bench/tcm_checker.sv
bench/tb_transition_count_model.sv
